// File: hw/rtl/gated_piecewise_linear_interpolator_defines.svh
// Assertion macros for the interpolator RTL.
`ifndef GATED_PIECEWISE_LINEAR_INTERPOLATOR_DEFINES_SVH
`define GATED_PIECEWISE_LINEAR_INTERPOLATOR_DEFINES_SVH

`ifndef SYNTH
`define GPLI_ASSERT(lbl, clk, rstn, prop) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) prop) \
    else $error("gpli assertion failed");
`define GPLI_NEVER(lbl, clk, rstn, cond) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) !(cond)) \
    else $error("gpli forbidden condition seen");
`else
`define GPLI_ASSERT(lbl, clk, rstn, prop)
`define GPLI_NEVER(lbl, clk, rstn, cond)
`endif

`endif

// File: hw/rtl/gpli_pkg.sv
// Types and constants of the gated piecewise-linear interpolator.
package gpli_pkg;

  localparam logic [15:0] BandLowQ6  = 16'd17920;  // 280 nm in Q10.6
  localparam logic [15:0] BandHighQ6 = 16'd42240;  // 660 nm in Q10.6
  localparam logic [19:0] OutMax     = 20'hFFFFF;
  localparam int unsigned DivSteps   = 32;

  localparam logic [1:0] CfgWindowLow  = 2'd0;
  localparam logic [1:0] CfgWindowHigh = 2'd1;
  localparam logic [1:0] CfgScaleRatio = 2'd2;
  localparam logic [1:0] CfgPeakEff    = 2'd3;

  typedef struct packed {
    logic        zero;
    logic        peak;
    logic [15:0] q;
  } gpli_tag_t;

  typedef struct packed {
    logic        found;
    logic [15:0] w0;
    logic [15:0] w1;
    logic [15:0] e0;
    logic [15:0] e1;
  } gpli_seg_t;

  typedef struct packed {
    logic        zero;
    logic        peak;
    logic        found;
    logic        span_zero;
    logic        neg;
    logic [15:0] e0;
  } gpli_side_t;

endpackage

// File: hw/rtl/gated_piecewise_linear_interpolator.sv
// Gated piecewise-linear interpolator: one query item can enter per cycle while the
// output is not stalled, and its result passes through 41 register stages (3 table
// stages, 3 arithmetic prep stages, a 32-stage divider, 3 scaling/output stages). A
// load item writes the point table as it is accepted and makes no result; it is held
// off while a query sits in either of the first two table stages. Configuration must
// be written only while idle; the block itself does not enforce this.
module gated_piecewise_linear_interpolator import gpli_pkg::*; #(
  parameter int unsigned TABLE_POINTS = 20
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        cfg_we_i,
  input  logic [1:0]  cfg_index_i,
  input  logic [15:0] cfg_data_i,
  input  logic        in_valid_i,
  output logic        in_stall_o,
  input  logic        kind_i,
  input  logic [4:0]  point_index_i,
  input  logic [15:0] point_wavelength_i,
  input  logic [15:0] point_efficiency_i,
  input  logic [15:0] query_wavelength_i,
  input  logic        mode_i,
  output logic        out_valid_o,
  input  logic        out_stall_i,
  output logic [19:0] efficiency_out_o
);

  logic [15:0] win_lo_q, win_hi_q, ratio_q, peak_q;

  logic        advance, accept, busy;
  gpli_tag_t   tag_in, loc_tag;
  gpli_seg_t   loc_seg;
  logic        loc_valid;

  logic               p1_v_q, p2_v_q, p3_v_q;
  logic signed [16:0] span1_q, de1_q, dq1_q, span2_q;
  gpli_side_t         side1_q, side2_q, side3_d, side3_q;
  logic signed [33:0] prod2_q, prod_neg;
  logic signed [16:0] span_neg;
  logic [31:0]        pmag3_q;
  logic [15:0]        smag3_q;

  logic        dv_valid;
  logic [31:0] dv_quo;
  gpli_side_t  dv_side;

  logic signed [33:0] qs, vsum;
  logic [31:0]        vpos_d, vpos_q;
  logic [47:0]        prod48_q;
  logic               f1_v_q, f2_v_q, out_v_q;
  logic [19:0]        out_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      win_lo_q <= 16'd0;
      win_hi_q <= 16'hFFFF;
      ratio_q  <= 16'd4096;
      peak_q   <= 16'd0;
    end else if (cfg_we_i) begin
      unique case (cfg_index_i)
        CfgWindowLow:  win_lo_q <= cfg_data_i;
        CfgWindowHigh: win_hi_q <= cfg_data_i;
        CfgScaleRatio: ratio_q  <= cfg_data_i;
        CfgPeakEff:    peak_q   <= cfg_data_i;
        default:       ;
      endcase
    end
  end

  assign advance    = !out_v_q || !out_stall_i;
  assign in_stall_o = !advance || (in_valid_i && !kind_i && busy);
  assign accept     = in_valid_i && !in_stall_o;

  always_comb begin
    tag_in.q    = query_wavelength_i;
    tag_in.peak = !mode_i;
    tag_in.zero = (query_wavelength_i <= win_lo_q) || (query_wavelength_i >= win_hi_q) ||
                  (mode_i && ((query_wavelength_i <= BandLowQ6) ||
                              (query_wavelength_i >= BandHighQ6)));
  end

  gpli_locate #(.TABLE_POINTS(TABLE_POINTS)) u_locate (
    .clk_i             (clk_i),
    .rst_ni            (rst_ni),
    .advance_i         (advance),
    .load_i            (accept && !kind_i),
    .point_index_i     (point_index_i),
    .point_wavelength_i(point_wavelength_i),
    .point_efficiency_i(point_efficiency_i),
    .query_i           (accept && kind_i),
    .tag_i             (tag_in),
    .busy_o            (busy),
    .valid_o           (loc_valid),
    .tag_o             (loc_tag),
    .seg_o             (loc_seg)
  );

  assign prod_neg = -prod2_q;
  assign span_neg = -span2_q;

  always_comb begin
    side3_d     = side2_q;
    side3_d.neg = prod2_q[33] ^ span2_q[16];
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      p1_v_q  <= 1'b0;
      p2_v_q  <= 1'b0;
      p3_v_q  <= 1'b0;
      f1_v_q  <= 1'b0;
      f2_v_q  <= 1'b0;
      out_v_q <= 1'b0;
    end else if (advance) begin
      p1_v_q  <= loc_valid;
      p2_v_q  <= p1_v_q;
      p3_v_q  <= p2_v_q;
      f1_v_q  <= dv_valid;
      f2_v_q  <= f1_v_q;
      out_v_q <= f2_v_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (advance) begin
      span1_q           <= $signed({1'b0, loc_seg.w1}) - $signed({1'b0, loc_seg.w0});
      de1_q             <= $signed({1'b0, loc_seg.e1}) - $signed({1'b0, loc_seg.e0});
      dq1_q             <= $signed({1'b0, loc_tag.q}) - $signed({1'b0, loc_seg.w0});
      side1_q.zero      <= loc_tag.zero;
      side1_q.peak      <= loc_tag.peak;
      side1_q.found     <= loc_seg.found;
      side1_q.span_zero <= loc_seg.w1 == loc_seg.w0;
      side1_q.neg       <= 1'b0;
      side1_q.e0        <= loc_seg.e0;

      prod2_q     <= de1_q * dq1_q;
      span2_q     <= span1_q;
      side2_q     <= side1_q;

      // magnitudes for the unsigned divider; sign restored after it
      pmag3_q     <= prod2_q[33] ? prod_neg[31:0] : prod2_q[31:0];
      smag3_q     <= span2_q[16] ? span_neg[15:0] : span2_q[15:0];
      side3_q     <= side3_d;

      vpos_q   <= vpos_d;
      prod48_q <= vpos_q * ratio_q;
      out_q    <= (|prod48_q[47:32]) ? OutMax : prod48_q[31:12];
    end
  end

  gpli_div u_div (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .advance_i (advance),
    .valid_i   (p3_v_q),
    .dividend_i(pmag3_q),
    .divisor_i (smag3_q),
    .side_i    (side3_q),
    .valid_o   (dv_valid),
    .quotient_o(dv_quo),
    .side_o    (dv_side)
  );

  assign qs   = dv_side.neg ? -$signed({2'b00, dv_quo}) : $signed({2'b00, dv_quo});
  assign vsum = $signed({18'd0, dv_side.e0}) + qs;

  // values at or above 2^32 saturate after any nonzero gain, so clamp there
  always_comb begin
    priority if (dv_side.zero) begin
      vpos_d = '0;
    end else if (dv_side.peak) begin
      vpos_d = {16'd0, peak_q};
    end else if (!dv_side.found) begin
      vpos_d = '0;
    end else if (dv_side.span_zero) begin
      vpos_d = {16'd0, dv_side.e0};
    end else if (vsum[33]) begin
      vpos_d = '0;
    end else if (vsum[32]) begin
      vpos_d = '1;
    end else begin
      vpos_d = vsum[31:0];
    end
  end

  assign out_valid_o      = out_v_q;
  assign efficiency_out_o = out_q;

endmodule

// File: hw/rtl/gpli_locate.sv
// Point table, segment search and segment fetch (three stages).
`include "gated_piecewise_linear_interpolator_defines.svh"
module gpli_locate import gpli_pkg::*; #(
  parameter int unsigned TABLE_POINTS = 20
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        advance_i,
  input  logic        load_i,
  input  logic [4:0]  point_index_i,
  input  logic [15:0] point_wavelength_i,
  input  logic [15:0] point_efficiency_i,
  input  logic        query_i,
  input  gpli_tag_t   tag_i,
  output logic        busy_o,
  output logic        valid_o,
  output gpli_tag_t   tag_o,
  output gpli_seg_t   seg_o
);

  localparam int unsigned Segs = TABLE_POINTS - 1;

  logic [15:0] wl_q [TABLE_POINTS];
  logic [15:0] el_q [TABLE_POINTS];

  logic            v1_q, v2_q, v3_q;
  gpli_tag_t       tag1_q, tag2_q, tag3_q;
  logic [Segs-1:0] hit_d, hit1_q, oh2_q;
  logic            found2_q;
  gpli_seg_t       seg_d, seg3_q;

  for (genvar i = 0; i < TABLE_POINTS; i++) begin : g_entry
    always_ff @(posedge clk_i or negedge rst_ni) begin
      if (!rst_ni) begin
        wl_q[i] <= '0;
        el_q[i] <= '0;
      end else if (load_i && ({27'd0, point_index_i} == 32'(i))) begin
        wl_q[i] <= point_wavelength_i;
        el_q[i] <= point_efficiency_i;
      end
    end
  end

  for (genvar i = 0; i < Segs; i++) begin : g_hit
    assign hit_d[i] = tag_i.q <= wl_q[i+1];
  end

  // AND-OR fetch of the chosen segment; no hit selects zeros
  always_comb begin
    seg_d       = '0;
    seg_d.found = found2_q;
    for (int i = 0; i < Segs; i++) begin
      seg_d.w0 = seg_d.w0 | ({16{oh2_q[i]}} & wl_q[i]);
      seg_d.w1 = seg_d.w1 | ({16{oh2_q[i]}} & wl_q[i+1]);
      seg_d.e0 = seg_d.e0 | ({16{oh2_q[i]}} & el_q[i]);
      seg_d.e1 = seg_d.e1 | ({16{oh2_q[i]}} & el_q[i+1]);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v1_q <= 1'b0;
      v2_q <= 1'b0;
      v3_q <= 1'b0;
    end else if (advance_i) begin
      v1_q <= query_i;
      v2_q <= v1_q;
      v3_q <= v2_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (advance_i) begin
      tag1_q   <= tag_i;
      hit1_q   <= hit_d;
      tag2_q   <= tag1_q;
      oh2_q    <= hit1_q & (~hit1_q + Segs'(1));  // first segment that hits
      found2_q <= |hit1_q;
      tag3_q   <= tag2_q;
      seg3_q   <= seg_d;
    end
  end

  // table reads happen in the first two stages
  assign busy_o  = v1_q || v2_q;
  assign valid_o = v3_q;
  assign tag_o   = tag3_q;
  assign seg_o   = seg3_q;

  `GPLI_NEVER(a_load_over_query, clk_i, rst_ni, load_i && v1_q)
  `GPLI_ASSERT(a_first_onehot, clk_i, rst_ni, v2_q |-> $onehot0(oh2_q))
  `GPLI_ASSERT(a_found_match, clk_i, rst_ni, v2_q |-> (found2_q == (oh2_q != '0)))

endmodule

// File: hw/rtl/gpli_div.sv
// Pipelined restoring divider, one quotient bit per stage.
module gpli_div import gpli_pkg::*; (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        advance_i,
  input  logic        valid_i,
  input  logic [31:0] dividend_i,
  input  logic [15:0] divisor_i,
  input  gpli_side_t  side_i,
  output logic        valid_o,
  output logic [31:0] quotient_o,
  output gpli_side_t  side_o
);

  logic        v_q   [DivSteps];
  logic [15:0] rem_q [DivSteps];
  logic [31:0] quo_q [DivSteps];
  logic [15:0] den_q [DivSteps];
  gpli_side_t  side_q[DivSteps];

  for (genvar s = 0; s < DivSteps; s++) begin : g_step
    logic        v_in;
    logic [15:0] rem_in, den_in;
    logic [31:0] quo_in;
    gpli_side_t  side_in;
    logic [16:0] rem_sh, diff;
    logic        ge;

    if (s == 0) begin : g_first
      assign v_in    = valid_i;
      assign rem_in  = '0;
      assign quo_in  = dividend_i;
      assign den_in  = divisor_i;
      assign side_in = side_i;
    end else begin : g_next
      assign v_in    = v_q[s-1];
      assign rem_in  = rem_q[s-1];
      assign quo_in  = quo_q[s-1];
      assign den_in  = den_q[s-1];
      assign side_in = side_q[s-1];
    end

    assign rem_sh = {rem_in, quo_in[31]};
    assign diff   = rem_sh - {1'b0, den_in};
    assign ge     = rem_sh >= {1'b0, den_in};

    always_ff @(posedge clk_i or negedge rst_ni) begin
      if (!rst_ni) begin
        v_q[s] <= 1'b0;
      end else if (advance_i) begin
        v_q[s] <= v_in;
      end
    end

    always_ff @(posedge clk_i) begin
      if (advance_i) begin
        rem_q[s]  <= ge ? diff[15:0] : rem_sh[15:0];
        quo_q[s]  <= {quo_in[30:0], ge};
        den_q[s]  <= den_in;
        side_q[s] <= side_in;
      end
    end
  end

  assign valid_o    = v_q[DivSteps-1];
  assign quotient_o = quo_q[DivSteps-1];
  assign side_o     = side_q[DivSteps-1];

endmodule

// File: tb/tb_gated_piecewise_linear_interpolator.sv
// Self-checking testbench for the gated piecewise-linear interpolator.
module tb_gated_piecewise_linear_interpolator;
  import gpli_pkg::*;

  localparam int NPTS = 20;
  localparam int LIMIT_CYCLES = 600000;

  logic        clk_i = 1'b0;
  logic        rst_ni = 1'b0;
  logic        cfg_we_i = 1'b0;
  logic [1:0]  cfg_index_i = '0;
  logic [15:0] cfg_data_i = '0;
  logic        in_valid_i = 1'b0;
  logic        in_stall_o;
  logic        kind_i = 1'b0;
  logic [4:0]  point_index_i = '0;
  logic [15:0] point_wavelength_i = '0;
  logic [15:0] point_efficiency_i = '0;
  logic [15:0] query_wavelength_i = '0;
  logic        mode_i = 1'b0;
  logic        out_valid_o;
  logic        out_stall_i = 1'b0;
  logic [19:0] efficiency_out_o;

  gated_piecewise_linear_interpolator dut (.*);

  always #5 clk_i = ~clk_i;

  // predictor state
  logic [15:0] win_lo, win_hi, ratio, peak;
  logic [15:0] tab_w [NPTS];
  logic [15:0] tab_e [NPTS];
  logic [19:0] expected_eff [$];

  int errors = 0;
  int results_seen = 0;
  int queries_sent = 0;
  int loads_sent = 0;
  int cycles = 0;
  int send_idle_pct = 0;
  int recv_stall_pct = 0;
  int hold_off = 0;

  function automatic longint lerp(logic [15:0] q);
    longint w0, w1, e0, e1, span;
    for (int i = 0; i + 1 < NPTS; i++) begin
      w0 = tab_w[i]; w1 = tab_w[i+1]; e0 = tab_e[i]; e1 = tab_e[i+1];
      if (longint'(q) <= w1) begin
        span = w1 - w0;
        if (span == 0) return e0;
        return e0 + ((e1 - e0) * (longint'(q) - w0)) / span;
      end
    end
    return 0;
  endfunction

  function automatic logic [19:0] scaled_efficiency(logic [15:0] q, logic m);
    longint v;
    longint s;
    if (q <= win_lo || q >= win_hi) v = 0;
    else if (!m) v = peak;
    else if (q <= BandLowQ6 || q >= BandHighQ6) v = 0;
    else v = lerp(q);
    if (v <= 0) return '0;
    s = (v * longint'(ratio)) >>> 12;
    return (s > longint'(OutMax)) ? OutMax : s[19:0];
  endfunction

  always @(posedge clk_i) begin
    cycles <= cycles + 1;
    if (cycles > LIMIT_CYCLES) begin
      $display("timeout after %0d cycles", cycles);
      $display("TB_ERROR");
      $finish;
    end
  end

  // receiver stall, with a long hold-off when requested
  always @(posedge clk_i) begin
    if (hold_off > 0) begin
      hold_off <= hold_off - 1;
      out_stall_i <= 1'b1;
    end else begin
      out_stall_i <= ($urandom_range(99) < recv_stall_pct);
    end
  end

  // result checker
  always @(posedge clk_i) begin
    logic [19:0] exp_v;
    if (rst_ni && out_valid_o && !out_stall_i) begin
      results_seen <= results_seen + 1;
      if (expected_eff.size() == 0) begin
        errors = errors + 1;
        if (errors <= 10) $display("unexpected result %0d", efficiency_out_o);
      end else begin
        exp_v = expected_eff.pop_front();
        if (exp_v !== efficiency_out_o) begin
          errors = errors + 1;
          if (errors <= 10)
            $display("mismatch: expected %0d actual %0d", exp_v, efficiency_out_o);
        end
      end
    end
  end

  task automatic write_reg(logic [1:0] idx, logic [15:0] val);
    cfg_we_i <= 1'b1;
    cfg_index_i <= idx;
    cfg_data_i <= val;
    @(posedge clk_i);
    cfg_we_i <= 1'b0;
    case (idx)
      CfgWindowLow:  win_lo = val;
      CfgWindowHigh: win_hi = val;
      CfgScaleRatio: ratio = val;
      default:       peak = val;
    endcase
  endtask

  // sends one item; valid stays high across back-to-back items
  task automatic send_item(logic k, logic [4:0] idx, logic [15:0] pw, logic [15:0] pe,
                           logic [15:0] q, logic m);
    while ($urandom_range(99) < send_idle_pct) begin
      in_valid_i <= 1'b0;
      @(posedge clk_i);
    end
    in_valid_i <= 1'b1;
    kind_i <= k;
    point_index_i <= idx;
    point_wavelength_i <= pw;
    point_efficiency_i <= pe;
    query_wavelength_i <= q;
    mode_i <= m;
    do @(posedge clk_i); while (in_stall_o);
    if (k) begin
      expected_eff.push_back(scaled_efficiency(q, m));
      queries_sent++;
    end else begin
      if (idx < NPTS) begin
        tab_w[idx] = pw;
        tab_e[idx] = pe;
      end
      loads_sent++;
    end
  endtask

  task automatic load_point(int idx, logic [15:0] w, logic [15:0] e);
    send_item(1'b0, idx[4:0], w, e, 16'($urandom), 1'($urandom));
  endtask

  task automatic query(logic [15:0] q, logic m);
    send_item(1'b1, 5'($urandom), 16'($urandom), 16'($urandom), q, m);
  endtask

  task automatic drain;
    in_valid_i <= 1'b0;
    while (expected_eff.size() != 0) @(posedge clk_i);
    repeat (50) @(posedge clk_i);
  endtask

  function automatic logic [15:0] band_q();
    return 16'($urandom_range(BandHighQ6 + 64, BandLowQ6 - 64));
  endfunction

  task automatic load_sorted_table;
    int w;
    w = $urandom_range(BandLowQ6 + 200, BandLowQ6 - 400);
    for (int i = 0; i < NPTS; i++) begin
      load_point(i, w[15:0], 16'($urandom));
      w += ($urandom_range(3) == 0) ? 0 : $urandom_range(1400);
      if (w > 65535) w = 65535;
    end
  endtask

  task automatic test_directed;
    query(16'd0, 1'b1);
    query(16'd100, 1'b0);
    drain();
    write_reg(CfgPeakEff, 16'hFFFF);
    query(16'hFFFF, 1'b0);
    query(16'hFFFE, 1'b0);
    query(16'd1, 1'b0);
    for (int i = 0; i < NPTS; i++)
      load_point(i, BandLowQ6 + 16'(i * 1280), 16'(i * 3000));
    load_point(25, 16'hFFFF, 16'hFFFF);  // out of range index, ignored
    load_point(31, 16'h1234, 16'h4321);
    query(BandLowQ6, 1'b1);
    query(BandLowQ6 + 16'd1, 1'b1);
    query(BandHighQ6 - 16'd1, 1'b1);
    query(BandHighQ6, 1'b1);
    query(BandLowQ6 + 16'd2000, 1'b1);
    load_point(5, BandLowQ6 + 16'(4 * 1280), 16'hFFFF);  // zero-width segment
    query(BandLowQ6 + 16'(4 * 1280) + 16'd5, 1'b1);
    load_point(7, 16'd100, 16'd0);  // unsorted table point
    query(BandLowQ6 + 16'(6 * 1280) + 16'd10, 1'b1);
    query(BandLowQ6 + 16'(7 * 1280) + 16'd10, 1'b1);
    drain();
    write_reg(CfgScaleRatio, 16'hFFFF);  // largest scale ratio
    query(BandLowQ6 + 16'(19 * 1280), 1'b1);
    query(16'd300, 1'b0);
    drain();
  endtask

  task automatic random_phase(int n, int idle, int stall);
    send_idle_pct = idle;
    recv_stall_pct = stall;
    for (int i = 0; i < n; i++) begin
      case ($urandom_range(9))
        0: load_point($urandom_range(31), 16'($urandom), 16'($urandom));
        1: load_point($urandom_range(NPTS - 1), band_q(), 16'($urandom));
        2: query(16'($urandom), 1'($urandom));
        default: query(band_q(), 1'b1);
      endcase
    end
    drain();
  endtask

  task automatic config_set(logic [15:0] lo, logic [15:0] hi, logic [15:0] r,
                            logic [15:0] p);
    write_reg(CfgWindowLow, lo);
    write_reg(CfgWindowHigh, hi);
    write_reg(CfgScaleRatio, r);
    write_reg(CfgPeakEff, p);
  endtask

  task automatic test_back_pressure;
    send_idle_pct = 0;
    recv_stall_pct = 0;
    hold_off <= 400;
    for (int i = 0; i < 150; i++) query(band_q(), 1'b1);
    drain();
  endtask

  initial begin
    win_lo = 16'd0; win_hi = 16'hFFFF; ratio = 16'd4096; peak = 16'd0;
    for (int i = 0; i < NPTS; i++) begin
      tab_w[i] = '0;
      tab_e[i] = '0;
    end
    repeat (11) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);
    test_directed();
    config_set(16'd0, 16'hFFFF, 16'd4096, 16'h8000);
    load_sorted_table();
    random_phase(450, 0, 0);
    config_set(BandLowQ6 + 16'd3000, BandHighQ6 - 16'd3000, 16'd2048, 16'h0001);
    load_sorted_table();
    random_phase(400, 48, 0);
    config_set(16'hFFFF, 16'd0, 16'hFFFF, 16'hFFFF);
    random_phase(100, 0, 48);
    config_set(16'd0, 16'hFFFF, 16'd0, 16'hFFFF);
    random_phase(100, 21, 21);
    config_set(16'd1, 16'hFFFE, 16'd20000, 16'hC000);
    load_sorted_table();
    random_phase(350, 0, 48);
    config_set(16'd100, 16'hF000, 16'd4096, 16'h7FFF);
    random_phase(350, 21, 21);
    test_back_pressure();
    $display("covered %0d queries and %0d table loads, %0d results checked",
             queries_sent, loads_sent, results_seen);
    $display("six register settings, idle/stall mixes and one long output hold-off");
    if (errors == 0) $display("TB_OK");
    else $display("TB_ERROR");
    $finish;
  end
endmodule
